// ===== rtl/radio_config_negotiation_responder_assert.svh =====
// Assertion macros shared by the responder RTL.
`ifndef RADIO_CONFIG_NEGOTIATION_RESPONDER_ASSERT_SVH
`define RADIO_CONFIG_NEGOTIATION_RESPONDER_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define RCNR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define RCNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcnr_pkg.sv =====
// Package with types and constants of the radio config negotiation responder.
package rcnr_pkg;

  localparam int SEQ_WIDTH = 8;

  localparam logic [15:0] DEFAULT_CONFIG_RESET = 16'h0000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_LISTEN    = 3'd0,
    MODE_ECHO_PEND = 3'd1,
    MODE_ACK_PEND  = 3'd2,
    MODE_WAIT      = 3'd3,
    MODE_HALTED    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_MSG      = 2'd1,
    CMD_TX_READY = 2'd2
  } cmd_t;

  localparam logic [2:0] MSG_ECHO_REQ   = 3'd0;
  localparam logic [2:0] MSG_CFG_START  = 3'd1;
  localparam logic [2:0] MSG_CFG_SET    = 3'd2;
  localparam logic [2:0] MSG_CFG_END    = 3'd3;

  localparam logic REG_DEFAULT_CONFIG = 1'b0;
  localparam logic REG_TIMEOUT_TICKS  = 1'b1;

  localparam logic SEND_ECHO_REPLY = 1'b0;
  localparam logic SEND_CONFIG_ACK = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] msg_type;
    logic [7:0] cfg_byte_hi;
    logic [7:0] cfg_byte_lo;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic       send_kind;
    logic [7:0] send_seq;
    logic       config_apply;
    logic [3:0] bandwidth_index;
    logic [3:0] spread_factor;
    logic [3:0] coding_rate;
    logic [5:0] tx_power;
    logic [2:0] mode;
    logic       unexpected_msg;
  } out_item_t;

  function automatic logic [6:0] bw_sf_key(input logic [15:0] word);
    return word[7:1];
  endfunction

endpackage

// ===== rtl/radio_config_negotiation_responder.sv =====
// Top level of the radio config negotiation responder.
//
// Events enter on the in channel (valid/ready): timer ticks, received
// messages and transmitter-ready reports. Every event gives exactly one
// result transaction on the out channel (valid/ready), which carries the
// reply to send, if any, and the radio settings after the event.
// Registers are written through the cfg channel, which is always ready;
// index 0 is the default config word and index 1 the timeout in ticks.
// An event is held in an input register and evaluated from there into the
// output register when that register is empty or being read; its result
// transaction is then offered. One event is accepted per cycle while the
// output side takes results; the single input register and single output
// register set that figure. When the receiver stalls, the output register
// holds its transaction and the input register holds one more event, after
// which in_ready drops. Reset returns to listen mode with the current and
// previous config words, the default word and the sequence count at zero,
// the timer cleared and the timeout at 1000 ticks.
module radio_config_negotiation_responder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rcnr_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcnr_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data
);

  logic                          held_valid;
  rcnr_pkg::in_item_t            held;
  logic                          advance;

  logic [15:0]                   default_config;
  logic [15:0]                   timeout_ticks;

  rcnr_pkg::mode_t               mode, mode_next;
  logic [15:0]                   current_config, current_config_next;
  logic [15:0]                   previous_config, previous_config_next;
  logic [15:0]                   wait_timer, wait_timer_next;
  logic [rcnr_pkg::SEQ_WIDTH-1:0] seq_count, seq_count_next;
  logic [15:0]                   timer_inc;
  rcnr_pkg::out_item_t           result;

  assign cfg_ready = 1'b1;
  assign advance   = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_config <= rcnr_pkg::DEFAULT_CONFIG_RESET;
      timeout_ticks  <= rcnr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcnr_pkg::REG_DEFAULT_CONFIG) begin
        default_config <= cfg_data;
      end else begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_data;
    end
  end

  assign timer_inc = (wait_timer == rcnr_pkg::TIMER_MAX) ? wait_timer
                                                         : wait_timer + 16'd1;

  always_comb begin
    mode_next            = mode;
    current_config_next  = current_config;
    previous_config_next = previous_config;
    wait_timer_next      = wait_timer;
    seq_count_next       = seq_count;
    result               = '0;

    unique case (held.cmd)
      rcnr_pkg::CMD_TICK: begin
        if (mode == rcnr_pkg::MODE_WAIT) begin
          wait_timer_next = timer_inc;
          if (timer_inc >= timeout_ticks) begin
            if (rcnr_pkg::bw_sf_key(current_config) !=
                rcnr_pkg::bw_sf_key(previous_config)) begin
              current_config_next = previous_config;
              result.config_apply = 1'b1;
              wait_timer_next     = '0;
            end else begin
              if (rcnr_pkg::bw_sf_key(current_config) !=
                  rcnr_pkg::bw_sf_key(default_config)) begin
                current_config_next = default_config;
                result.config_apply = 1'b1;
              end
              mode_next = rcnr_pkg::MODE_LISTEN;
            end
          end
        end
      end
      rcnr_pkg::CMD_MSG: begin
        if (mode == rcnr_pkg::MODE_LISTEN) begin
          if (held.msg_type == rcnr_pkg::MSG_ECHO_REQ) begin
            mode_next = rcnr_pkg::MODE_ECHO_PEND;
          end else if (held.msg_type == rcnr_pkg::MSG_CFG_START) begin
            mode_next       = rcnr_pkg::MODE_WAIT;
            wait_timer_next = '0;
          end else begin
            result.unexpected_msg = 1'b1;
          end
        end else if (mode == rcnr_pkg::MODE_WAIT) begin
          wait_timer_next = '0;
          if (held.msg_type == rcnr_pkg::MSG_CFG_SET) begin
            previous_config_next = current_config;
            current_config_next  = {held.cfg_byte_lo, held.cfg_byte_hi};
            result.config_apply  = 1'b1;
            mode_next            = rcnr_pkg::MODE_ACK_PEND;
          end else if (held.msg_type == rcnr_pkg::MSG_CFG_END) begin
            mode_next = rcnr_pkg::MODE_LISTEN;
          end else begin
            mode_next = rcnr_pkg::MODE_HALTED;
          end
        end
      end
      rcnr_pkg::CMD_TX_READY: begin
        if (mode == rcnr_pkg::MODE_ECHO_PEND || mode == rcnr_pkg::MODE_ACK_PEND) begin
          result.send_valid = 1'b1;
          result.send_seq   = 8'(seq_count);
          seq_count_next    = seq_count + {{(rcnr_pkg::SEQ_WIDTH-1){1'b0}}, 1'b1};
          if (mode == rcnr_pkg::MODE_ACK_PEND) begin
            result.send_kind = rcnr_pkg::SEND_CONFIG_ACK;
            mode_next        = rcnr_pkg::MODE_WAIT;
            wait_timer_next  = '0;
          end else begin
            result.send_kind = rcnr_pkg::SEND_ECHO_REPLY;
            mode_next        = rcnr_pkg::MODE_LISTEN;
          end
        end
      end
      default: begin
      end
    endcase

    result.bandwidth_index = current_config_next[7:4];
    result.spread_factor   = 4'd6 + {1'b0, current_config_next[3:1]};
    result.coding_rate     = 4'd5 + {2'b00, current_config_next[15:14]};
    result.tx_power        = 6'd2 + {1'b0, current_config_next[13:9]};
    result.mode            = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= rcnr_pkg::MODE_LISTEN;
      current_config  <= rcnr_pkg::DEFAULT_CONFIG_RESET;
      previous_config <= rcnr_pkg::DEFAULT_CONFIG_RESET;
      wait_timer      <= '0;
      seq_count       <= '0;
    end else if (advance) begin
      mode            <= mode_next;
      current_config  <= current_config_next;
      previous_config <= previous_config_next;
      wait_timer      <= wait_timer_next;
      seq_count       <= seq_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`include "radio_config_negotiation_responder_assert.svh"

  `RCNR_ASSERT_NEXT(a_halt_sticks, mode == rcnr_pkg::MODE_HALTED,
    mode == rcnr_pkg::MODE_HALTED, "halted mode was left without reset")
  `RCNR_ASSERT_SAME(a_ack_to_wait,
    out_valid && out_data.send_valid && out_data.send_kind,
    out_data.mode == rcnr_pkg::MODE_WAIT, "acknowledge transaction did not report wait mode")
  `RCNR_ASSERT_SAME(a_echo_to_listen,
    out_valid && out_data.send_valid && !out_data.send_kind,
    out_data.mode == rcnr_pkg::MODE_LISTEN, "echo reply transaction did not report listen mode")
  `RCNR_ASSERT_SAME(a_idle_reply_clear, out_valid && !out_data.send_valid,
    !out_data.send_kind && out_data.send_seq == 8'd0, "reply fields set without a reply")
  `RCNR_ASSERT_NEXT(a_stall_holds_state, held_valid && out_valid && !out_ready,
    $stable(mode) && $stable(seq_count), "state changed while the output was stalled")

endmodule

// ===== verif/radio_config_negotiation_responder_tb.sv =====
// Self-checking testbench for the radio config negotiation responder.
module radio_config_negotiation_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [2:0] MSG_OTHER_MIN = 3'd4;
  localparam logic [2:0] MSG_OTHER_MAX = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_EVENTS = 450;
  localparam int PRINT_LIMIT = 30;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rcnr_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rcnr_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = rcnr_pkg::REG_DEFAULT_CONFIG;
  logic [15:0]         cfg_data = '0;

  radio_config_negotiation_responder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  rcnr_pkg::mode_t                link_mode;
  logic [15:0]                    active_word;
  logic [15:0]                    prior_word;
  logic [15:0]                    fallback_word;
  logic [15:0]                    timeout_limit;
  logic [15:0]                    idle_ticks;
  logic [rcnr_pkg::SEQ_WIDTH-1:0] reply_seq;

  rcnr_pkg::out_item_t expected_responses[$];
  int        mismatches = 0;
  int        events_sent = 0;
  int        results_seen = 0;
  int        replies_seen = 0;
  int        applies_seen = 0;
  bit        steady_flow = 1'b0;

  function automatic rcnr_pkg::out_item_t radio_response(input rcnr_pkg::in_item_t ev);
    rcnr_pkg::out_item_t r;
    r = '0;
    case (ev.cmd)
      rcnr_pkg::CMD_TICK: begin
        if (link_mode == rcnr_pkg::MODE_WAIT) begin
          if (idle_ticks != rcnr_pkg::TIMER_MAX) idle_ticks = idle_ticks + 16'd1;
          if (idle_ticks >= timeout_limit) begin
            if (active_word[7:1] != prior_word[7:1]) begin
              active_word = prior_word;
              r.config_apply = 1'b1;
              idle_ticks = '0;
            end else begin
              if (active_word[7:1] != fallback_word[7:1]) begin
                active_word = fallback_word;
                r.config_apply = 1'b1;
              end
              link_mode = rcnr_pkg::MODE_LISTEN;
            end
          end
        end
      end
      rcnr_pkg::CMD_MSG: begin
        if (link_mode == rcnr_pkg::MODE_LISTEN) begin
          if (ev.msg_type == rcnr_pkg::MSG_ECHO_REQ) begin
            link_mode = rcnr_pkg::MODE_ECHO_PEND;
          end else if (ev.msg_type == rcnr_pkg::MSG_CFG_START) begin
            link_mode = rcnr_pkg::MODE_WAIT;
            idle_ticks = '0;
          end else begin
            r.unexpected_msg = 1'b1;
          end
        end else if (link_mode == rcnr_pkg::MODE_WAIT) begin
          idle_ticks = '0;
          if (ev.msg_type == rcnr_pkg::MSG_CFG_SET) begin
            prior_word = active_word;
            active_word = {ev.cfg_byte_lo, ev.cfg_byte_hi};
            r.config_apply = 1'b1;
            link_mode = rcnr_pkg::MODE_ACK_PEND;
          end else if (ev.msg_type == rcnr_pkg::MSG_CFG_END) begin
            link_mode = rcnr_pkg::MODE_LISTEN;
          end else begin
            link_mode = rcnr_pkg::MODE_HALTED;
          end
        end
      end
      rcnr_pkg::CMD_TX_READY: begin
        if (link_mode == rcnr_pkg::MODE_ECHO_PEND || link_mode == rcnr_pkg::MODE_ACK_PEND) begin
          r.send_valid = 1'b1;
          r.send_kind = (link_mode == rcnr_pkg::MODE_ACK_PEND) ? rcnr_pkg::SEND_CONFIG_ACK
                                                               : rcnr_pkg::SEND_ECHO_REPLY;
          r.send_seq = 8'(reply_seq);
          reply_seq = reply_seq + {{(rcnr_pkg::SEQ_WIDTH-1){1'b0}}, 1'b1};
          if (link_mode == rcnr_pkg::MODE_ACK_PEND) begin
            link_mode = rcnr_pkg::MODE_WAIT;
            idle_ticks = '0;
          end else begin
            link_mode = rcnr_pkg::MODE_LISTEN;
          end
        end
      end
      default: ;
    endcase
    r.bandwidth_index = active_word[7:4];
    r.spread_factor = 4'd6 + {1'b0, active_word[3:1]};
    r.coding_rate = 4'd5 + {2'b00, active_word[15:14]};
    r.tx_power = 6'd2 + {1'b0, active_word[13:9]};
    r.mode = link_mode;
    return r;
  endfunction

  function automatic rcnr_pkg::in_item_t make_event(input logic [1:0] cmd,
                                                    input logic [2:0] mtype,
                                                    input logic [15:0] word);
    rcnr_pkg::in_item_t ev;
    ev.cmd = cmd;
    ev.msg_type = mtype;
    ev.cfg_byte_hi = word[7:0];
    ev.cfg_byte_lo = word[15:8];
    return ev;
  endfunction

  // Mostly well-formed negotiation steps for the current mode, with some noise.
  function automatic rcnr_pkg::in_item_t random_event();
    rcnr_pkg::in_item_t ev;
    int                 roll;
    int                 bias;
    logic [15:0]        word;
    roll = $urandom_range(0, 99);
    bias = $urandom_range(0, 9);
    word = 16'($urandom);
    if (bias < 2) begin
      word[7:1] = active_word[7:1];
    end else if (bias == 2) begin
      word[7:1] = fallback_word[7:1];
    end
    ev = make_event(rcnr_pkg::CMD_MSG, 3'($urandom), word);
    case (link_mode)
      rcnr_pkg::MODE_LISTEN: begin
        if (roll < 40) begin
          ev.msg_type = rcnr_pkg::MSG_CFG_START;
        end else if (roll < 65) begin
          ev.msg_type = rcnr_pkg::MSG_ECHO_REQ;
        end else if (roll < 78) begin
          ev.cmd = rcnr_pkg::CMD_MSG;
        end else if (roll < 88) begin
          ev.cmd = rcnr_pkg::CMD_TICK;
        end else if (roll < 95) begin
          ev.cmd = rcnr_pkg::CMD_TX_READY;
        end else begin
          ev.cmd = CMD_IGNORED;
        end
      end
      rcnr_pkg::MODE_WAIT: begin
        if (roll < 45) begin
          ev.cmd = rcnr_pkg::CMD_TICK;
        end else if (roll < 80) begin
          ev.msg_type = rcnr_pkg::MSG_CFG_SET;
        end else if (roll < 92) begin
          ev.msg_type = rcnr_pkg::MSG_CFG_END;
        end else if (roll < 96) begin
          ev.cmd = rcnr_pkg::CMD_TX_READY;
        end else begin
          ev.cmd = CMD_IGNORED;
        end
      end
      default: begin
        if (roll < 70) begin
          ev.cmd = rcnr_pkg::CMD_TX_READY;
        end else if (roll < 80) begin
          ev.cmd = rcnr_pkg::CMD_TICK;
        end else if (roll < 92) begin
          ev.cmd = rcnr_pkg::CMD_MSG;
        end else begin
          ev.cmd = CMD_IGNORED;
        end
      end
    endcase
    return ev;
  endfunction

  function automatic bit take_break();
    return !steady_flow && ($urandom_range(0, 99) < 7);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  task automatic send_event(input rcnr_pkg::in_item_t ev);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_responses.push_back(radio_response(ev));
    events_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == rcnr_pkg::REG_DEFAULT_CONFIG) begin
      fallback_word = value;
    end else begin
      timeout_limit = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin : result_check
    rcnr_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (out_data.send_valid === 1'b1) replies_seen++;
      if (out_data.config_apply === 1'b1) applies_seen++;
      if (expected_responses.size() == 0) begin
        report_mismatch("result transaction with no event pending", '0, '0);
      end else begin
        want = expected_responses.pop_front();
        check_field("send_valid", 16'(out_data.send_valid), 16'(want.send_valid));
        check_field("send_kind", 16'(out_data.send_kind), 16'(want.send_kind));
        check_field("send_seq", 16'(out_data.send_seq), 16'(want.send_seq));
        check_field("config_apply", 16'(out_data.config_apply), 16'(want.config_apply));
        check_field("bandwidth_index", 16'(out_data.bandwidth_index),
                    16'(want.bandwidth_index));
        check_field("spread_factor", 16'(out_data.spread_factor), 16'(want.spread_factor));
        check_field("coding_rate", 16'(out_data.coding_rate), 16'(want.coding_rate));
        check_field("tx_power", 16'(out_data.tx_power), 16'(want.tx_power));
        check_field("mode", 16'(out_data.mode), 16'(want.mode));
        check_field("unexpected_msg", 16'(out_data.unexpected_msg),
                    16'(want.unexpected_msg));
      end
    end
  end

  task automatic test_reset_state();
    send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_TICK, rcnr_pkg::MSG_CFG_SET, 16'hFFFF));
    send_event(make_event(CMD_IGNORED, MSG_OTHER_MAX, 16'h0000));
    wait_for_results();
  endtask

  task automatic test_echo_reply();
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_START, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_TICK, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    wait_for_results();
  endtask

  task automatic test_unexpected_messages();
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_SET, 16'h1234));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_END, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, MSG_OTHER_MIN, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, MSG_OTHER_MAX, 16'h0000));
    wait_for_results();
  endtask

  // Two config sets, then a timeout back to the previous word, then to the default.
  task automatic test_negotiation_fallback();
    write_register(rcnr_pkg::REG_DEFAULT_CONFIG, 16'h5A3C);
    write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'd2);
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_START, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_SET, 16'hFFFF));
    send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_SET, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    repeat (4) send_event(make_event(rcnr_pkg::CMD_TICK, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_START, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_END, 16'h0000));
    wait_for_results();
  endtask

  task automatic test_random_negotiation();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(rcnr_pkg::REG_DEFAULT_CONFIG, 16'hFFFF);
          write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'd1);
        end
        1: begin
          write_register(rcnr_pkg::REG_DEFAULT_CONFIG, 16'($urandom));
          write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(2, 6)));
        end
        2: begin
          write_register(rcnr_pkg::REG_DEFAULT_CONFIG, 16'h0000);
          write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        end
        default: begin
          write_register(rcnr_pkg::REG_DEFAULT_CONFIG, 16'($urandom));
          write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'd3);
        end
      endcase
      steady_flow = (phase == 1);
      repeat (PHASE_EVENTS) send_event(random_event());
      wait_for_results();
      steady_flow = 1'b0;
    end
  endtask

  // Halting can only be undone by reset, so this runs last.
  task automatic test_halt();
    write_register(rcnr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
    while (link_mode != rcnr_pkg::MODE_WAIT) begin
      if (link_mode == rcnr_pkg::MODE_LISTEN) begin
        send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_START, 16'h0000));
      end else begin
        send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
      end
    end
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_START, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_MSG, rcnr_pkg::MSG_CFG_SET, 16'hA5A5));
    send_event(make_event(rcnr_pkg::CMD_TX_READY, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    send_event(make_event(rcnr_pkg::CMD_TICK, rcnr_pkg::MSG_ECHO_REQ, 16'h0000));
    wait_for_results();
  endtask

  initial begin
    link_mode = rcnr_pkg::MODE_LISTEN;
    fallback_word = rcnr_pkg::DEFAULT_CONFIG_RESET;
    timeout_limit = rcnr_pkg::TIMEOUT_RESET;
    active_word = rcnr_pkg::DEFAULT_CONFIG_RESET;
    prior_word = rcnr_pkg::DEFAULT_CONFIG_RESET;
    idle_ticks = '0;
    reply_seq = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_echo_reply();
    test_unexpected_messages();
    test_negotiation_fallback();
    test_random_negotiation();
    test_halt();
    wait_for_results();
    $display("Covered %0d events and %0d result transactions: %0d replies, %0d config changes,",
             events_sent, results_seen, replies_seen, applies_seen);
    $display("across echo, negotiation, timeout fallback and halt, with several register settings.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results still pending.", expected_responses.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
